>>> rtl/msd_pkg.sv
// shared types and constants for the mean / standard deviation bounds block
// no dependencies; imported by msd_divider, msd_sqrt and the top level
package msd_pkg;

    // fixed widths of the result fields
    localparam int MEAN_W  = 16;
    localparam int BOUND_W = 17;
    localparam int COUNT_W = 5;

    // status of an iterative arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

>>> rtl/mean_std_deviation_bounds_core.sv
// One sample item per cycle while loading; input stalled from the last item to the result.
// Last item to result: a mean divider run, a pass over the sample store, a variance divider
// run, the root, then the output register, plus any output stall.
// Both divider runs use the one shared divider.
// Synchronous active-low reset clears sum, count, flags, sequencer and output valid.
module mean_std_deviation_bounds_core import msd_pkg::*; #(
    parameter int MAX_SAMPLES = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_last_sample,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [MEAN_W-1:0]      o_mean,
    output logic [BOUND_W-1:0]     o_low_bound,
    output logic [BOUND_W-1:0]     o_high_bound,
    output logic [COUNT_W-1:0]     o_sample_count,
    output logic                   o_truncated
);

    localparam int AW    = $clog2(MAX_SAMPLES);
    localparam int CW    = $clog2(MAX_SAMPLES + 1);
    localparam int SUMW  = SAMPLE_BITS + CW;
    localparam int SQRW  = 2 * SAMPLE_BITS;
    localparam int ACCW  = SQRW + CW;
    localparam int EXTW  = SAMPLE_BITS + CW + BOUND_W;
    localparam logic [CW-1:0] FULL = CW'(MAX_SAMPLES);

    // sequencer states
    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_MEAN = 3'd1;
    localparam logic [2:0] S_SQ   = 3'd2;
    localparam logic [2:0] S_VAR  = 3'd3;
    localparam logic [2:0] S_ROOT = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]             r_state, n_state;
    logic                   r_div_start, n_div_start;
    logic                   r_root_start, n_root_start;

    logic [SAMPLE_BITS-1:0] r_mem [MAX_SAMPLES];
    logic [SAMPLE_BITS-1:0] r_rd_data;
    logic [SUMW-1:0]        r_sum;
    logic [CW-1:0]          r_count;
    logic                   r_overflow;
    logic [CW-1:0]          r_idx;
    logic                   r_p1;
    logic                   r_p2;
    logic [SQRW-1:0]        r_sqr;
    logic [ACCW-1:0]        r_acc;
    logic [SAMPLE_BITS-1:0] r_mean;
    logic [SAMPLE_BITS-1:0] r_dev;

    logic                   r_out_valid;
    logic [MEAN_W-1:0]      r_out_mean;
    logic [BOUND_W-1:0]     r_out_low;
    logic [BOUND_W-1:0]     r_out_high;
    logic [COUNT_W-1:0]     r_out_count;
    logic                   r_out_trunc;

    logic                   w_accept;
    logic                   w_out_free;
    logic                   w_issue;
    logic                   w_pass_end;
    logic [SAMPLE_BITS-1:0] w_absd;
    logic [ACCW-1:0]        w_dividend;
    logic [ACCW-1:0]        w_quo;
    logic [SAMPLE_BITS-1:0] w_root;
    t_unit_stat             w_div_stat;
    t_unit_stat             w_root_stat;
    logic [EXTW-1:0]        w_mean_x;
    logic [EXTW-1:0]        w_dev_x;
    logic [EXTW-1:0]        w_low_x;
    logic [EXTW-1:0]        w_high_x;
    logic [EXTW-1:0]        w_count_x;

    assign w_accept   = i_valid && (r_state == S_LOAD);
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_issue    = (r_state == S_SQ) && (r_idx != r_count);
    assign w_pass_end = (r_state == S_SQ) && (r_idx == r_count) && !r_p1 && !r_p2;

    // shared divider: sum / count, then squared deviations / count
    assign w_dividend = (r_state == S_MEAN) ? ACCW'(r_sum) : r_acc;

    msd_divider #(
        .DIVIDEND_W (ACCW),
        .DIVISOR_W  (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_count),
        .o_stat     (w_div_stat),
        .o_quotient (w_quo)
    );

    msd_sqrt #(
        .IN_W    (SQRW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_root_start),
        .i_value (w_quo[SQRW-1:0]),
        .o_stat  (w_root_stat),
        .o_root  (w_root)
    );

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_div_start  = 1'b0;
        n_root_start = 1'b0;
        case (r_state)
            S_LOAD: begin
                if (w_accept && i_last_sample && !w_div_stat.busy) begin
                    n_state     = S_MEAN;
                    n_div_start = 1'b1;
                end
            end
            S_MEAN: begin
                if (w_div_stat.done) begin
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                if (w_pass_end) begin
                    n_state     = S_VAR;
                    n_div_start = 1'b1;
                end
            end
            S_VAR: begin
                if (w_div_stat.done) begin
                    n_state      = S_ROOT;
                    n_root_start = 1'b1;
                end
            end
            S_ROOT: begin
                if (w_root_stat.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_div_start  <= 1'b0;
            r_root_start <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_div_start  <= n_div_start;
            r_root_start <= n_root_start;
        end
    end

    // sample store, one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_accept && (r_count != FULL)) begin
            r_mem[r_count[AW-1:0]] <= i_sample;
        end
        r_rd_data <= r_mem[r_idx[AW-1:0]];
    end

    // running sum, count and overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_count    <= '0;
            r_overflow <= 1'b0;
        end else if ((r_state == S_OUT) && w_out_free) begin
            r_sum      <= '0;
            r_count    <= '0;
            r_overflow <= 1'b0;
        end else if (w_accept) begin
            if (r_count != FULL) begin
                r_sum   <= r_sum + SUMW'(i_sample);
                r_count <= r_count + 1'b1;
            end else begin
                r_overflow <= 1'b1;
            end
        end
    end

    // deviation pass: read, square, accumulate
    assign w_absd = (r_rd_data >= r_mean) ? (r_rd_data - r_mean) : (r_mean - r_rd_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1 <= 1'b0;
            r_p2 <= 1'b0;
        end else begin
            r_p1 <= w_issue;
            r_p2 <= r_p1;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_MEAN) && w_div_stat.done) begin
            r_mean <= w_quo[SAMPLE_BITS-1:0];
            r_idx  <= '0;
            r_acc  <= '0;
        end else begin
            if (w_issue) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_p2) begin
                r_acc <= r_acc + ACCW'(r_sqr);
            end
        end
        r_sqr <= {{SAMPLE_BITS{1'b0}}, w_absd} * {{SAMPLE_BITS{1'b0}}, w_absd};
        if ((r_state == S_ROOT) && w_root_stat.done) begin
            r_dev <= w_root;
        end
    end

    // result fields, truncated to their widths
    assign w_mean_x  = EXTW'(r_mean);
    assign w_dev_x   = EXTW'(r_dev);
    assign w_low_x   = w_mean_x - w_dev_x;
    assign w_high_x  = w_mean_x + w_dev_x;
    assign w_count_x = EXTW'(r_count);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_OUT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && w_out_free) begin
            r_out_mean  <= w_mean_x[MEAN_W-1:0];
            r_out_low   <= w_low_x[BOUND_W-1:0];
            r_out_high  <= w_high_x[BOUND_W-1:0];
            r_out_count <= w_count_x[COUNT_W-1:0];
            r_out_trunc <= r_overflow;
        end
    end

    assign o_stall        = (r_state != S_LOAD);
    assign o_valid        = r_out_valid;
    assign o_mean         = r_out_mean;
    assign o_low_bound    = r_out_low;
    assign o_high_bound   = r_out_high;
    assign o_sample_count = r_out_count;
    assign o_truncated    = r_out_trunc;

endmodule

>>> rtl/msd_divider.sv
// restoring divider, one quotient bit per cycle
// depends on msd_pkg (t_unit_stat)
module msd_divider import msd_pkg::*; #(
    parameter int DIVIDEND_W = 37,
    parameter int DIVISOR_W  = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output t_unit_stat            o_stat,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);
    localparam logic [CNT_W-1:0] STEPS = CNT_W'(DIVIDEND_W);

    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [DIVISOR_W:0]    w_trial;
    logic [DIVISOR_W:0]    w_diff;

    // trial subtract of the shifted remainder
    assign w_trial = {r_rem, r_quo[DIVIDEND_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEPS;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            if (!w_diff[DIVISOR_W]) begin
                r_rem <= w_diff[DIVISOR_W-1:0];
                r_quo <= {r_quo[DIVIDEND_W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[DIVISOR_W-1:0];
                r_quo <= {r_quo[DIVIDEND_W-2:0], 1'b0};
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

>>> rtl/msd_sqrt.sv
// floor integer square root, one result bit per cycle
// depends on msd_pkg (t_unit_stat); IN_W must be even
module msd_sqrt import msd_pkg::*; #(
    parameter int IN_W = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [IN_W-1:0]   i_value,
    output t_unit_stat        o_stat,
    output logic [IN_W/2-1:0] o_root
);

    logic [IN_W-1:0] r_rem;
    logic [IN_W-1:0] r_res;
    logic [IN_W-1:0] r_bit;
    logic            r_busy;
    logic            r_done;

    logic [IN_W-1:0] w_sum;

    assign w_sum = r_res + r_bit;

    // control: stop after the weight-one step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_value;
            r_res <= '0;
            r_bit <= {2'b01, {(IN_W-2){1'b0}}};
        end else if (r_busy) begin
            if (r_rem >= w_sum) begin
                r_rem <= r_rem - w_sum;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_root      = r_res[IN_W/2-1:0];

endmodule
